>>> hw/rtl/csvfs_pkg.sv
`timescale 1ns / 1ps

package csvfs_pkg;

  localparam int DEF_MAX_FIELD_BYTES = 1024;
  localparam int DEF_MAX_FIELDS      = 256;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // parse phases
  localparam logic [1:0] PH_START       = 2'd0;
  localparam logic [1:0] PH_QUOTED      = 2'd1;
  localparam logic [1:0] PH_UNQUOTED    = 2'd2;
  localparam logic [1:0] PH_AFTER_QUOTE = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  // APB register map
  localparam int               APB_AW       = 3;
  localparam logic [APB_AW-1:0] ADDR_FIELD_CAP = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [9:0] byte_position;
    logic [7:0] field_index;
    logic [9:0] field_length;
    logic       was_quoted;
    logic       last_in_line;
  } res_t;

endpackage

>>> hw/rtl/csv_field_splitter.sv
`timescale 1ns / 1ps

// An accepted beat's result is registered, in the skid slot if the output is stalled.
// Throughput: one input beat per cycle while s_tready is high; each gives one result at most.
// The output register plus a one-entry skid stage keep s_tready registered.
// Reset (rst, synchronous, active high): parser back to field start, all counters
// cleared, both output slots emptied, field_capacity back to 1024.
module csv_field_splitter import csvfs_pkg::*; #(
  parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES,
  parameter int MAX_FIELDS      = DEF_MAX_FIELDS
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] char_byte
  input  logic              s_tlast,   // end_of_line
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [7:0] data_byte, [17:8] byte_position,
                                       // [25:18] field_index, [35:26] field_length,
                                       // [36] was_quoted, [39:37] zero
  output logic [1:0]        m_tuser,   // [1:0] kind
  output logic              m_tlast,   // last_in_line
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // stored_count never exceeds MAX_FIELD_BYTES-1, so clog2 bits hold it
  localparam int CNT_W = (MAX_FIELD_BYTES > 2) ? $clog2(MAX_FIELD_BYTES) : 1;
  localparam int FC_W  = $clog2(MAX_FIELDS);
  // compare width covers the 11-bit register and MAX_FIELD_BYTES itself
  localparam int CMP_W = ((CNT_W + 1) > CFG_W) ? (CNT_W + 2) : (CFG_W + 1);
  localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(MAX_FIELD_BYTES);
  localparam logic [FC_W-1:0]  FC_LIMIT = FC_W'(MAX_FIELDS - 1);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] field_capacity;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_capacity <= CAP_RESET;
    end else if (cfg_wr && paddr == ADDR_FIELD_CAP) begin
      field_capacity <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_FIELD_CAP) begin
      prdata = 32'(field_capacity);
    end
  end

  // Effective capacity: zero acts as one, anything above the buffer size is clipped.
  logic [CMP_W-1:0] cap_eff;
  always_comb begin
    priority if (field_capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(field_capacity) > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = CMP_W'(field_capacity);
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  logic [1:0]      phase,         phase_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [CNT_W-1:0] trim_start,   trim_start_next;
  logic            trim_pending,  trim_pending_next;
  logic [FC_W-1:0] field_counter, field_counter_next;

  logic       in_acc;
  logic [7:0] b;
  logic       blank;
  logic       store_ok;
  logic       have_res;
  res_t       res;
  logic [CNT_W-1:0] unq_len;
  logic [FC_W-1:0]  fc_inc;

  assign in_acc  = s_tvalid && s_tready;
  assign b       = s_tdata;
  assign blank   = (b != 8'd0) && (b <= CH_SPACE);
  // a byte is kept only while the buffer still leaves room for its terminator
  assign store_ok = (CMP_W'(stored_count) + CMP_W'(1)) < cap_eff;
  assign unq_len  = trim_pending ? trim_start : stored_count;
  assign fc_inc   = (field_counter < FC_LIMIT) ? field_counter + FC_W'(1) : field_counter;

  always_comb begin
    phase_next         = phase;
    stored_count_next  = stored_count;
    trim_start_next    = trim_start;
    trim_pending_next  = trim_pending;
    field_counter_next = field_counter;
    have_res           = 1'b0;
    res                = '0;
    res.field_index    = 8'(field_counter);

    if (s_tlast) begin
      // terminator closes any open field, else reports an empty line end
      have_res         = 1'b1;
      res.last_in_line = 1'b1;
      unique case (phase)
        PH_QUOTED: begin
          res.kind         = KIND_FIELD_END;
          res.field_length = 10'(stored_count);
          res.was_quoted   = 1'b1;
        end
        PH_UNQUOTED: begin
          res.kind         = KIND_FIELD_END;
          res.field_length = 10'(unq_len);
        end
        default: begin
          res.kind = KIND_LINE_END;
        end
      endcase
      phase_next         = PH_START;
      stored_count_next  = '0;
      trim_start_next    = '0;
      trim_pending_next  = 1'b0;
      field_counter_next = '0;
    end else begin
      // a comma at field start is an empty field; the quote opens a quoted field;
      // any other byte (incl. whitespace) opens an unquoted one. stored_count is
      // already zero outside an open field.
      unique case (phase)
        PH_QUOTED: begin
          if (b == CH_QUOTE) begin
            have_res           = 1'b1;
            res.kind           = KIND_FIELD_END;
            res.field_length   = 10'(stored_count);
            res.was_quoted     = 1'b1;
            field_counter_next = fc_inc;
            stored_count_next  = '0;
            trim_start_next    = '0;
            trim_pending_next  = 1'b0;
            phase_next         = PH_AFTER_QUOTE;
          end else if (store_ok) begin
            have_res           = 1'b1;
            res.kind           = KIND_BYTE;
            res.data_byte      = b;
            res.byte_position  = 10'(stored_count);
            stored_count_next  = stored_count + CNT_W'(1);
          end
        end
        default: begin
          if (phase == PH_AFTER_QUOTE && blank) begin
            // whitespace after the closing quote is skipped
          end else if (phase == PH_AFTER_QUOTE && b == CH_COMMA) begin
            phase_next = PH_START;
          end else if (phase != PH_UNQUOTED && b == CH_QUOTE) begin
            phase_next = PH_QUOTED;
          end else if (b == CH_COMMA) begin
            have_res           = 1'b1;
            res.kind           = KIND_FIELD_END;
            res.field_length   = (phase == PH_UNQUOTED) ? 10'(unq_len) : 10'd0;
            field_counter_next = fc_inc;
            stored_count_next  = '0;
            trim_start_next    = '0;
            trim_pending_next  = 1'b0;
            phase_next         = PH_START;
          end else begin
            phase_next = PH_UNQUOTED;
            // trailing-whitespace tracking; trim point is the count before the
            // first blank of the current run
            if (blank) begin
              if (!trim_pending) begin
                trim_start_next   = stored_count;
                trim_pending_next = 1'b1;
              end
            end else begin
              trim_pending_next = 1'b0;
            end
            if (store_ok) begin
              have_res          = 1'b1;
              res.kind          = KIND_BYTE;
              res.data_byte     = b;
              res.byte_position = 10'(stored_count);
              stored_count_next = stored_count + CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      stored_count  <= '0;
      trim_start    <= '0;
      trim_pending  <= 1'b0;
      field_counter <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      stored_count  <= stored_count_next;
      trim_start    <= trim_start_next;
      trim_pending  <= trim_pending_next;
      field_counter <= field_counter_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid slot
  // ---------------------------------------------------------------------------
  logic out_valid, skid_valid;
  res_t out_res,   skid_res;
  logic out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc && have_res;
      end
    end else if (in_acc && have_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && in_acc && have_res) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last_in_line;
  assign m_tdata  = {3'b000, out_res.was_quoted, out_res.field_length,
                     out_res.field_index, out_res.byte_position, out_res.data_byte};

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a beat while output register is empty");

  a_trim_in_range: assert property (@(posedge clk) disable iff (rst)
    trim_start <= stored_count)
    else $error("trim point beyond stored count");

  a_byte_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE) |-> !m_tlast)
    else $error("byte beat flagged as line end");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=>
      (phase == PH_START && field_counter == '0 && stored_count == '0))
    else $error("parser not cleared after line terminator");
`endif

endmodule
